@@ hdl/ascii_range_frame_parser_core_assert.svh @@
// Assertion helpers used by the checker file.
`ifndef ASCII_RANGE_FRAME_PARSER_CORE_ASSERT_SVH
`define ASCII_RANGE_FRAME_PARSER_CORE_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define ARFP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("arfp assertion failed");

// Signal holds its value in the cycle after cond.
`define ARFP_STABLE(lbl, clk, rst, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error("arfp stability check failed");

`endif

@@ hdl/arfp_pkg.sv @@
package arfp_pkg;

  localparam logic [7:0]  CHAR_M   = 8'h6D;
  localparam logic [7:0]  CHAR_0   = 8'h30;
  localparam logic [7:0]  CHAR_9   = 8'h39;
  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;
  localparam logic [3:0]  DEC_BASE = 4'd10;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take a byte into the window, start a scan
    logic shift1;  // advance scan by one slot
    logic shift2;  // skip the "mm" pair, clear the accumulator
    logic step;    // fold one digit in, advance scan
    logic commit;  // update held distance and output register
    logic found;   // pair was found for this item
  } arfp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_live;  // scan slot still a legal pair start
    logic pair;         // "mm" at scan head
    logic digit_go;     // digit at scan head, inside window, not saturated
  } arfp_sts_t;

endpackage

@@ hdl/arfp_byte_if.sv @@
interface arfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/arfp_dist_if.sv @@
interface arfp_dist_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance_mm;
  logic        frame_found;

  modport source (output valid, output distance_mm, output frame_found, input ready);
  modport sink   (input valid, input distance_mm, input frame_found, output ready);
endinterface

@@ hdl/arfp_ctrl.sv @@
module arfp_ctrl
  import arfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  arfp_sts_t sts,
  output arfp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SKIP,
    ST_DIGITS,
    ST_WRITE
  } state_t;

  state_t state;
  logic   found;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.found  = found;
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.shift1 = (state == ST_SEARCH) && sts.search_live && !sts.pair;
    cmd.shift2 = (state == ST_SKIP);
    cmd.step   = (state == ST_DIGITS) && sts.digit_go;
    cmd.commit = (state == ST_WRITE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one taken in this cycle
      if ((state == ST_WRITE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (!sts.search_live) begin
            found <= 1'b0;
            state <= ST_WRITE;
          end else if (sts.pair) begin
            found <= 1'b1;
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          state <= ST_DIGITS;
        end
        ST_DIGITS: begin
          if (!sts.digit_go) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/arfp_datapath.sv @@
module arfp_datapath
  import arfp_pkg::*;
#(
  parameter int WINDOW_LEN  = 20,
  parameter int SEARCH_SPAN = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  arfp_cmd_t   cmd,
  output arfp_sts_t   sts,
  input  logic [7:0]  rx_byte,
  output logic [31:0] distance_mm,
  output logic        frame_found
);

  localparam int PW = $clog2(WINDOW_LEN + 1);

  logic [7:0]    window [WINDOW_LEN];
  logic [7:0]    scan   [WINDOW_LEN];
  logic [PW-1:0] pos;

  // digit accumulator; weight stays at or below 10^9 while not over
  logic [31:0] value;
  logic [29:0] weight;
  logic        over;
  logic        sat;
  logic [31:0] held;

  logic        head_digit;
  logic [3:0]  digit;
  logic [33:0] prod;
  logic [34:0] sum;
  logic [33:0] weight_x10;
  logic [31:0] result;
  logic [31:0] held_next;

  assign head_digit = (scan[0] >= CHAR_0) && (scan[0] <= CHAR_9);
  assign digit      = scan[0][3:0];
  assign prod       = 34'(digit) * 34'(weight);
  assign sum        = 35'(value) + 35'(prod);
  assign weight_x10 = 34'(weight) * 34'(DEC_BASE);
  assign result     = sat ? DIST_MAX : value;
  assign held_next  = cmd.found ? result : held;

  assign sts.search_live = (int'(pos) < SEARCH_SPAN) && (int'(pos) + 1 < WINDOW_LEN);
  assign sts.pair        = (scan[0] == CHAR_M) && (scan[1] == CHAR_M);
  assign sts.digit_go    = (pos < PW'(WINDOW_LEN)) && head_digit && !sat;

  // history window, newest byte at slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        window[k] <= '0;
      end
    end else if (cmd.load) begin
      window[0] <= rx_byte;
      for (int k = 1; k < WINDOW_LEN; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  // scan copy: slot pos of the window always sits at scan[0]
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan[0] <= rx_byte;
      for (int k = 1; k < WINDOW_LEN; k++) begin
        scan[k] <= window[k-1];
      end
      pos <= '0;
    end else if (cmd.shift1 || cmd.step) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        scan[k] <= (k + 1 < WINDOW_LEN) ? scan[(k + 1) % WINDOW_LEN] : '0;
      end
      pos <= pos + PW'(1);
    end else if (cmd.shift2) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        scan[k] <= (k + 2 < WINDOW_LEN) ? scan[(k + 2) % WINDOW_LEN] : '0;
      end
      pos <= pos + PW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift2) begin
      value  <= '0;
      weight <= 30'd1;
      over   <= 1'b0;
      sat    <= 1'b0;
    end else if (cmd.step) begin
      if (digit != 4'd0) begin
        if (over || (sum > 35'(DIST_MAX))) begin
          sat <= 1'b1;
        end else begin
          value <= sum[31:0];
        end
      end
      if (!over) begin
        if (weight_x10 > 34'(DIST_MAX)) begin
          over <= 1'b1;
        end else begin
          weight <= weight_x10[29:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.commit) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      distance_mm <= held_next;
      frame_found <= cmd.found;
    end
  end

endmodule

@@ hdl/ascii_range_frame_parser_core.sv @@
// Per byte: the controller steps the scan register through up to SEARCH_SPAN slots
// looking for "mm", skips the pair, reads the digit run behind it, then writes the result.
// The next byte is taken only after that write; a result still waiting for the sink
// stalls the write.
// Reset (rst, synchronous, active high): window cleared to zero, held distance zero,
// no result pending, controller idle.
module ascii_range_frame_parser_core
  import arfp_pkg::*;
#(
  parameter int WINDOW_LEN  = 20,
  parameter int SEARCH_SPAN = 10
) (
  input  logic       clk,
  input  logic       rst,
  arfp_byte_if.sink  rx,
  arfp_dist_if.source res
);

  // Flow: an accepted byte is shifted into the window and copied into a scan
  // register. The controller steps the scan register one slot per cycle looking
  // for "mm" at its head, skips the pair, then folds in one digit per cycle
  // (digit times weight, add, saturate check). The result goes to an output
  // register; the next byte is taken once the result is written there, even while
  // that result still waits for the sink.

  arfp_cmd_t cmd;
  arfp_sts_t sts;

  arfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arfp_datapath #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SEARCH_SPAN (SEARCH_SPAN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .rx_byte     (rx.rx_byte),
    .distance_mm (res.distance_mm),
    .frame_found (res.frame_found)
  );

endmodule

@@ hdl/arfp_checker.sv @@
`include "ascii_range_frame_parser_core_assert.svh"

module arfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] distance_mm,
  input logic        frame_found
);

  // distance of the last item taken by the sink
  logic [31:0] last_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_dist <= '0;
    end else if (out_valid && out_ready) begin
      last_dist <= distance_mm;
    end
  end

  `ARFP_STABLE(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ARFP_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `ARFP_ASSERT(a_miss_keeps_dist, clk, rst, (out_valid && !frame_found) |-> (distance_mm == last_dist))
  `ARFP_ASSERT(a_result_after_scan, clk, rst, $rose(out_valid) |-> $past(!in_ready))

endmodule

bind ascii_range_frame_parser_core arfp_checker u_arfp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (rx.valid),
  .in_ready    (rx.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .distance_mm (res.distance_mm),
  .frame_found (res.frame_found)
);

@@ bench/ascii_range_frame_parser_core_test.sv @@
module ascii_range_frame_parser_core_test;
  import arfp_pkg::*;

  localparam int WIN_LEN     = 20;
  localparam int SPAN        = 10;
  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int HANG_LIMIT  = 5000;
  // Wait at the end for longer than the worst scan latency.
  localparam int TAIL_CYCLES = 64;
  localparam int RAND_ITEMS  = 1250;

  // One expected result item.
  typedef struct packed {
    logic [31:0] reading;
    logic        found;
  } range_rec_t;

  // One row of the directed script. When typed is set, the expected result is
  // taken from the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic [31:0] reading;
    logic        found;
  } script_row_t;

  localparam script_row_t SCRIPT [28] = '{
    // fresh window, single 'm' is no marker
    '{CHAR_M, 1'b1, 32'd0, 1'b0},
    // "mm" right after reset: window behind it is zeros, so no digits
    '{CHAR_M, 1'b1, 32'd0, 1'b1},
    // non-ASCII byte pushes the pair to slot 1; digit slot holds 0x00
    '{8'hFF,  1'b1, 32'd0, 1'b1},
    // exact full-scale reading
    '{"4", 1'b0, 32'd0, 1'b0}, '{"2", 1'b0, 32'd0, 1'b0},
    '{"9", 1'b0, 32'd0, 1'b0}, '{"4", 1'b0, 32'd0, 1'b0},
    '{"9", 1'b0, 32'd0, 1'b0}, '{"6", 1'b0, 32'd0, 1'b0},
    '{"7", 1'b0, 32'd0, 1'b0}, '{"2", 1'b0, 32'd0, 1'b0},
    '{"9", 1'b0, 32'd0, 1'b0}, '{"5", 1'b0, 32'd0, 1'b0},
    '{CHAR_M, 1'b0, 32'd0, 1'b0},
    '{CHAR_M, 1'b1, DIST_MAX, 1'b1},
    // one above full scale saturates
    '{"4", 1'b0, 32'd0, 1'b0}, '{"2", 1'b0, 32'd0, 1'b0},
    '{"9", 1'b0, 32'd0, 1'b0}, '{"4", 1'b0, 32'd0, 1'b0},
    '{"9", 1'b0, 32'd0, 1'b0}, '{"6", 1'b0, 32'd0, 1'b0},
    '{"7", 1'b0, 32'd0, 1'b0}, '{"2", 1'b0, 32'd0, 1'b0},
    '{"9", 1'b0, 32'd0, 1'b0}, '{"6", 1'b0, 32'd0, 1'b0},
    '{CHAR_M, 1'b0, 32'd0, 1'b0},
    '{CHAR_M, 1'b1, DIST_MAX, 1'b1},
    // zero byte moves the pair to slot 1, same digits read again
    '{8'h00,  1'b1, DIST_MAX, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  arfp_byte_if rx ();
  arfp_dist_if res ();

  ascii_range_frame_parser_core #(
    .WINDOW_LEN (WIN_LEN),
    .SEARCH_SPAN(SPAN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res)
  );

  always #2 clk = ~clk;

  // Predictor state: byte history (slot 0 newest) and the held reading.
  logic [7:0]  hist [WIN_LEN];
  logic [31:0] held_mm;

  range_rec_t  pending_ranges [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          hung_cycles = 0;
  // High during a stretch where neither side inserts idle cycles.
  logic        steady = 1'b0;

  // Value of the digit run starting at slot first. Nearest digit is the units
  // digit. Leading zeros at high weights are harmless; any nonzero digit past
  // 32-bit weight, or a sum over 32 bits, clips to full scale.
  function automatic logic [31:0] digit_run_value(input int first);
    logic [63:0] acc;
    logic [63:0] wgt;
    logic        wgt_big;
    logic        clipped;
    logic [7:0]  c;
    int          p;
    acc     = '0;
    wgt     = 64'd1;
    wgt_big = 1'b0;
    clipped = 1'b0;
    for (p = first; p < WIN_LEN; p++) begin
      c = hist[p];
      if (c < CHAR_0 || c > CHAR_9) break;
      if (c != CHAR_0) begin
        if (wgt_big) begin
          clipped = 1'b1;
        end else begin
          acc = acc + 64'(c - CHAR_0) * wgt;
          if (acc > 64'(DIST_MAX)) clipped = 1'b1;
        end
      end
      if (clipped) break;
      if (!wgt_big) begin
        wgt = wgt * 64'(DEC_BASE);
        if (wgt > 64'(DIST_MAX)) wgt_big = 1'b1;
      end
    end
    return clipped ? DIST_MAX : acc[31:0];
  endfunction

  // Shift one byte in, look for the newest "mm" in the search span, and
  // return the held reading plus the found flag.
  function automatic void track_range(input logic [7:0] b, output range_rec_t r);
    int s;
    for (s = WIN_LEN - 1; s > 0; s--) hist[s] = hist[s - 1];
    hist[0] = b;
    r.found = 1'b0;
    for (s = 0; s < SPAN; s++) begin
      if (s + 1 >= WIN_LEN) break;
      if (hist[s] == CHAR_M && hist[s + 1] == CHAR_M) begin
        held_mm = digit_run_value(s + 2);
        r.found = 1'b1;
        break;
      end
    end
    r.reading = held_mm;
  endfunction

  // Offer one byte. Called at a falling edge, returns at a falling edge with
  // valid still high so back-to-back items need only one assignment per step.
  task automatic send_byte(input logic [7:0] b, input logic typed, input range_rec_t want);
    range_rec_t got;
    while (!steady && $urandom_range(99) < 9) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    track_range(b, got);
    pending_ranges.push_back(typed ? want : got);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected result item is back.
  task automatic drain_results();
    rx.valid <= 1'b0;
    do @(negedge clk); while (pending_ranges.size() != 0);
  endtask

  // Noise byte: stray 'm', stray digit, or anything at all.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(3))
      0:       return CHAR_M;
      1:       return CHAR_0 + 8'($urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random stimulus: mostly well-formed readings "<digits>mm<tail>", some
  // broken markers and plain noise.
  task automatic send_traffic();
    int         ndig;
    int         ntail;
    int         k;
    logic [7:0] c;
    logic       drained;
    drained = 1'b0;
    while (bytes_sent < RAND_ITEMS + $size(SCRIPT)) begin
      if (!drained && bytes_sent > 900) begin
        drain_results();
        drained = 1'b1;
      end
      if ($urandom_range(9) < 8) begin
        // digit run: usually short, sometimes long enough to reach the last slot
        ndig = ($urandom_range(9) == 0) ? $urandom_range(WIN_LEN + 1, 12)
                                        : $urandom_range(11);
        for (k = 0; k < ndig; k++) begin
          case ($urandom_range(5))
            0:       c = CHAR_0;
            1:       c = CHAR_9;
            default: c = CHAR_0 + 8'($urandom_range(9));
          endcase
          send_byte(c, 1'b0, '0);
        end
        send_byte(CHAR_M, 1'b0, '0);
        // one in eight markers is broken by a byte in the middle
        if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)), 1'b0, '0);
        send_byte(CHAR_M, 1'b0, '0);
        // trailer walks the pair through the search span and past it
        ntail = $urandom_range(SPAN + 2);
        for (k = 0; k < ntail; k++) begin
          c = ($urandom_range(3) == 0) ? noise_byte() : 8'($urandom_range(255));
          send_byte(c, 1'b0, '0);
        end
      end else begin
        ntail = $urandom_range(8, 1);
        for (k = 0; k < ntail; k++) send_byte(noise_byte(), 1'b0, '0);
      end
    end
  endtask

  // Result side: random back-pressure except in the steady stretch.
  initial res.ready = 1'b0;
  always @(negedge clk) res.ready <= steady || ($urandom_range(99) >= 9);

  // Check every result item against the oldest expectation.
  always @(posedge clk) begin
    range_rec_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_ranges.size() == 0) begin
        $display("%0t: unexpected result item: distance_mm=%0d frame_found=%0b",
                 $time, res.distance_mm, res.frame_found);
        mismatches++;
      end else begin
        want = pending_ranges.pop_front();
        if (res.distance_mm !== want.reading) begin
          $display("%0t: distance_mm expected %0d, got %0d",
                   $time, want.reading, res.distance_mm);
          mismatches++;
        end
        if (res.frame_found !== want.found) begin
          $display("%0t: frame_found expected %0b, got %0b",
                   $time, want.found, res.frame_found);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: counts cycles where no item moves on either channel.
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
      hung_cycles <= 0;
    end else if (hung_cycles >= HANG_LIMIT) begin
      $display("ascii_range_frame_parser_core: mismatch");
      $finish;
    end else begin
      hung_cycles <= hung_cycles + 1;
    end
  end

  // Stretch with no idling on either side.
  always @(negedge clk) steady <= (bytes_sent >= 500 && bytes_sent < 700);

  initial begin
    int i;
    range_rec_t want;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    for (i = 0; i < WIN_LEN; i++) hist[i] = '0;
    held_mm = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed script.
    for (i = 0; i < $size(SCRIPT); i++) begin
      want.reading = SCRIPT[i].reading;
      want.found   = SCRIPT[i].found;
      send_byte(SCRIPT[i].b, SCRIPT[i].typed, want);
    end
    drain_results();

    send_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ascii_range_frame_parser_core: match");
    end else begin
      $display("ascii_range_frame_parser_core: mismatch");
    end
    $finish;
  end

endmodule

@@ ascii_range_frame_parser_core.f @@
+incdir+hdl
hdl/arfp_pkg.sv
hdl/arfp_byte_if.sv
hdl/arfp_dist_if.sv
hdl/arfp_ctrl.sv
hdl/arfp_datapath.sv
hdl/ascii_range_frame_parser_core.sv
hdl/arfp_checker.sv
bench/ascii_range_frame_parser_core_test.sv
